[sv/afpp_pkg.sv]
package afpp_pkg;

   localparam int MODULUS_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int SEED_WIDTH = 64;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] modulus;
      logic [SEED_WIDTH-1:0]  seed;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] multiplier;
      logic [FIELD_WIDTH-1:0] increment;
   } rsp_type;

endpackage

[sv/afpp_divider.sv]
// Restoring divider, one quotient bit per cycle. Gives quotient and remainder.
module afpp_divider #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic [W:0]    shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[sv/affine_full_period_params.sv]
// Picks full-period LCG parameters (multiplier, increment) for a modulus. One
// transaction at a time: req_ready is low while an item is worked on. All
// divisions run through one shared bit-serial divider that is max(64,
// MODULUS_WIDTH) bits wide. The multiplier needs trial division up to sqrt(M)
// (two divisions per candidate, one per factor stripped); the increment needs
// a seed reduction plus a Euclid gcd per candidate. A 32-bit prime modulus
// tries about 65534 candidates; a modulus of 0 or 1 skips the divider. The
// product of primes is formed by one narrow multiply per new prime, registered.
module affine_full_period_params #(
   parameter int MODULUS_WIDTH = afpp_pkg::MODULUS_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  afpp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output afpp_pkg::rsp_type rsp_data
);

   localparam int W  = MODULUS_WIDTH;
   localparam int DW = afpp_pkg::SEED_WIDTH > W ? afpp_pkg::SEED_WIDTH : W;
   localparam int FW = afpp_pkg::FIELD_WIDTH;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_TCHK   = 4'd1;  // p <= n/p ?
   localparam logic [3:0] S_TMOD   = 4'd2;  // n % p
   localparam logic [3:0] S_STRIP  = 4'd3;  // n / p while divisible
   localparam logic [3:0] S_MULT   = 4'd4;  // rad *= p
   localparam logic [3:0] S_AFIN   = 4'd5;
   localparam logic [3:0] S_BSEED  = 4'd6;  // seed % m
   localparam logic [3:0] S_GCD    = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;
   localparam logic [3:0] S_WAIT   = 4'd9;  // wait for divider

   logic [3:0]    state_ff, state_in;
   logic [3:0]    ret_ff, ret_in;
   logic [W-1:0]  m_ff, m_in;
   logic [W-1:0]  n_ff, n_in;
   logic [W-1:0]  p_ff, p_in;
   logic [W-1:0]  rad_ff, rad_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  gx_ff, gx_in;
   logic [W-1:0]  gy_ff, gy_in;
   logic [W-1:0]  a_ff, a_in;
   logic [afpp_pkg::SEED_WIDTH-1:0] seed_ff, seed_in;
   logic          rsp_valid_ff, rsp_valid_in;
   afpp_pkg::rsp_type rsp_ff, rsp_in;

   logic          div_start;
   logic [DW-1:0] div_a, div_b;
   logic          div_done;
   logic [DW-1:0] div_q, div_r;
   logic [W-1:0]  q_w, r_w;
   logic [W-1:0]  m_raw;
   logic [W-1:0]  base;
   logic [W-1:0]  b_next;
   logic [2*W-1:0] prod;

   afpp_divider #(.W(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign q_w = div_q[W-1:0];
   assign r_w = div_r[W-1:0];

   generate
      if (W >= FW) begin : g_wide
         assign m_raw = W'(req_data.modulus);
      end else begin : g_narrow
         assign m_raw = req_data.modulus[W-1:0];
      end
   endgenerate

   assign prod = rad_ff * p_ff;

   always_comb begin
      base = rad_ff;
      if (m_ff[1:0] == 2'b00) base = {rad_ff[W-2:0], 1'b0};
      b_next = b_ff + 1'b1;
      if (b_next == m_ff) b_next = W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      rad_in       = rad_ff;
      b_in         = b_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      a_in         = a_ff;
      seed_in      = seed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      div_a        = '0;
      div_b        = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               m_in    = m_raw;
               n_in    = m_raw;
               p_in    = W'(2);
               rad_in  = W'(1);
               seed_in = req_data.seed;
               if (m_raw <= W'(1)) begin
                  a_in     = W'(1);
                  b_in     = '0;
                  state_in = S_OUT;
               end else begin
                  div_start = 1'b1;
                  div_a     = DW'(m_raw);
                  div_b     = DW'(W'(2));
                  ret_in    = S_TCHK;
                  state_in  = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            if (div_done) state_in = ret_ff;
         end
         S_TCHK: begin
            // divider holds n/p
            if (p_ff <= q_w) begin
               div_start = 1'b1;
               div_a     = DW'(n_ff);
               div_b     = DW'(p_ff);
               ret_in    = S_TMOD;
               state_in  = S_WAIT;
            end else begin
               if (n_ff > W'(1)) begin
                  p_in     = n_ff;
                  state_in = S_MULT;
                  ret_in   = S_AFIN;
               end else begin
                  state_in = S_AFIN;
               end
            end
         end
         S_TMOD: begin
            if (r_w == '0) begin
               n_in     = q_w;
               state_in = S_MULT;
               ret_in   = S_STRIP;
            end else begin
               p_in      = p_ff + 1'b1;
               div_start = 1'b1;
               div_a     = DW'(n_ff);
               div_b     = DW'(p_ff + 1'b1);
               ret_in    = S_TCHK;
               state_in  = S_WAIT;
            end
         end
         S_MULT: begin
            rad_in = prod[W-1:0];
            if (ret_ff == S_AFIN) begin
               state_in = S_AFIN;
            end else begin
               div_start = 1'b1;
               div_a     = DW'(n_ff);
               div_b     = DW'(p_ff);
               state_in  = S_WAIT;
            end
         end
         S_STRIP: begin
            // divider holds n/p, n%p
            if (r_w == '0) begin
               n_in      = q_w;
               div_start = 1'b1;
               div_a     = DW'(q_w);
               div_b     = DW'(p_ff);
               ret_in    = S_STRIP;
               state_in  = S_WAIT;
            end else begin
               p_in      = p_ff + 1'b1;
               div_start = 1'b1;
               div_a     = DW'(n_ff);
               div_b     = DW'(p_ff + 1'b1);
               ret_in    = S_TCHK;
               state_in  = S_WAIT;
            end
         end
         S_AFIN: begin
            if (base >= m_ff || base + 1'b1 == m_ff) a_in = W'(1);
            else a_in = base + 1'b1;
            div_start = 1'b1;
            div_a     = DW'(seed_ff);
            div_b     = DW'(m_ff);
            ret_in    = S_BSEED;
            state_in  = S_WAIT;
         end
         S_BSEED: begin
            b_in  = (r_w == '0) ? W'(1) : r_w;
            gx_in = m_ff;
            gy_in = (r_w == '0) ? W'(1) : r_w;
            state_in = S_GCD;
         end
         S_GCD: begin
            // gcd(b, m) by Euclid: x <- y, y <- x % y
            if (gy_ff == '0) begin
               if (gx_ff == W'(1)) begin
                  state_in = S_OUT;
               end else begin
                  b_in  = b_next;
                  gx_in = m_ff;
                  gy_in = b_next;
               end
            end else begin
               div_start = 1'b1;
               div_a     = DW'(gx_ff);
               div_b     = DW'(gy_ff);
               gx_in     = gy_ff;
               ret_in    = S_GCD;
               state_in  = S_WAIT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.multiplier = FW'(a_ff);
               rsp_in.increment  = FW'(b_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_WAIT && div_done && ret_ff == S_GCD) gy_in = r_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff  <= ret_in;
      m_ff    <= m_in;
      n_ff    <= n_in;
      p_ff    <= p_in;
      rad_ff  <= rad_in;
      b_ff    <= b_in;
      gx_ff   <= gx_in;
      gy_ff   <= gy_in;
      a_ff    <= a_in;
      seed_ff <= seed_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/afpp_checker.sv]
module afpp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input afpp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input afpp_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request dropped or changed while waiting");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a second item while busy");

   a_trivial_inc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.increment == '0 |-> rsp_data.multiplier == 32'd1)
      else $error("zero increment without unit multiplier");

   a_nonzero_mult: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.multiplier != '0)
      else $error("multiplier is zero");

endmodule

bind affine_full_period_params afpp_checker u_afpp_checker (.*);
